// ===== rtl/hds_pkg.sv =====
// Shared types and fixed widths for the harmonic distance score unit.
// No dependencies; the top-level unit imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_AXES   = 3;
  localparam int OUT_W      = 48;
  localparam int REST_W     = 31;
  localparam int STIFF_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // derived datapath widths
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DIST_W  = SUM_W / 2;
  localparam int DIFF_W  = (DIST_W > REST_W) ? DIST_W : REST_W;
  localparam int T_W     = 2 * DIFF_W;
  localparam int TL_W    = DIFF_W;
  localparam int TH_W    = T_W - TL_W;
  localparam int KT_W    = STIFF_W + T_W;
  localparam int KD_W    = STIFF_W + DIFF_W;
  localparam int DV_W    = KD_W - FRAC_BITS;
  localparam int DVL_W   = DV_W / 2;
  localparam int DVH_W   = DV_W - DVL_W;
  localparam int NUM_W   = DV_W + MAG_W;
  localparam int SCORE_SH = 2 * FRAC_BITS + 1;

  localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(65536);
  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST_LENGTH = 1'b0,
    REG_STIFFNESS   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      want_derivatives;
  } in_word_t;

  typedef struct packed {
    logic        [OUT_W-1:0] score;
    logic signed [OUT_W-1:0] deriv_x;
    logic signed [OUT_W-1:0] deriv_y;
    logic signed [OUT_W-1:0] deriv_z;
  } out_word_t;

  // carried alongside the root extraction
  typedef struct packed {
    logic                               want;
    logic [NUM_AXES-1:0]                neg;
    logic [NUM_AXES-1:0][MAG_W-1:0]     mag;
  } pair_side_t;

  // carried alongside the division
  typedef struct packed {
    logic [OUT_W-1:0]    score;
    logic                zero;
    logic [NUM_AXES-1:0] sgn;
  } div_side_t;

endpackage

`default_nettype wire

// ===== rtl/hds_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
// No package dependency; widths come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module hds_sqrt_pipe #(
  parameter  int IN_W   = 68,
  parameter  int SIDE_W = 1,
  localparam int ROOT_W = IN_W / 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [IN_W-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int RW = ROOT_W + 2;

  logic [IN_W-1:0]   rad_q  [ROOT_W+1];
  logic [IN_W-1:0]   rad_d  [ROOT_W+1];
  logic [RW-1:0]     rem_q  [ROOT_W+1];
  logic [RW-1:0]     rem_d  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [ROOT_W-1:0] root_d [ROOT_W+1];
  logic [SIDE_W-1:0] side_q [ROOT_W+1];
  logic [ROOT_W:0]   valid_q;

  always_comb begin
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    logic [RW+1:0] sub;
    logic          ge;
    rad_d[0]  = rad_i;
    rem_d[0]  = '0;
    root_d[0] = '0;
    for (int s = 0; s < ROOT_W; s++) begin
      // bring down two radicand bits, try root*4+1
      rem_t = {rem_q[s], rad_q[s][IN_W-1 -: 2]};
      trial = {2'b00, root_q[s], 2'b01};
      sub   = rem_t - trial;
      ge    = (rem_t >= trial);
      rem_d[s+1]  = ge ? sub[RW-1:0] : rem_t[RW-1:0];
      root_d[s+1] = {root_q[s][ROOT_W-2:0], ge};
      rad_d[s+1]  = rad_q[s] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ROOT_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s <= ROOT_W; s++) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
      for (int s = 1; s <= ROOT_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/hds_div_pipe.sv =====
// Pipelined restoring divider, several lanes sharing one divisor.
// Gives a Q_W-bit quotient per lane and a flag when it would not fit.
`timescale 1ns / 1ps
`default_nettype none

module hds_div_pipe #(
  parameter int NUM_W  = 83,
  parameter int DEN_W  = 34,
  parameter int Q_W    = 48,
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]              den_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               valid_o,
  output logic [LANES-1:0][Q_W-1:0]          q_o,
  output logic [LANES-1:0]                   sat_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int HI_W = NUM_W - Q_W;

  logic [LANES-1:0][DEN_W-1:0] rem_q [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0] rem_d [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   lo_q  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   lo_d  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quo_q [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quo_d [Q_W+1];
  logic [LANES-1:0]            sat_q [Q_W+1];
  logic [LANES-1:0]            sat_d;
  logic [DEN_W-1:0]            den_q [Q_W+1];
  logic [SIDE_W-1:0]           side_q [Q_W+1];
  logic [Q_W:0]                valid_q;

  always_comb begin
    logic [DEN_W:0] rem_t;
    logic [DEN_W:0] den_x;
    logic [DEN_W:0] sub;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      // quotient overflows Q_W bits when the upper part already reaches d
      sat_d[l]    = (num_i[l][NUM_W-1:Q_W] >= HI_W'(den_i));
      rem_d[0][l] = num_i[l][Q_W+DEN_W-1:Q_W];
      lo_d[0][l]  = num_i[l][Q_W-1:0];
      quo_d[0][l] = '0;
    end
    for (int s = 0; s < Q_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem_t = {rem_q[s][l], lo_q[s][l][Q_W-1]};
        den_x = {1'b0, den_q[s]};
        sub   = rem_t - den_x;
        ge    = (rem_t >= den_x);
        rem_d[s+1][l] = ge ? sub[DEN_W-1:0] : rem_t[DEN_W-1:0];
        quo_d[s+1][l] = {quo_q[s][l][Q_W-2:0], ge};
        lo_d[s+1][l]  = lo_q[s][l] << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= sat_d;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int s = 0; s <= Q_W; s++) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        quo_q[s] <= quo_d[s];
      end
      for (int s = 1; s <= Q_W; s++) begin
        sat_q[s]  <= sat_q[s-1];
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[Q_W];
  assign q_o     = quo_q[Q_W];
  assign sat_o   = sat_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

`default_nettype wire

// ===== rtl/harmonic_distance_score_unit.sv =====
// Harmonic distance restraint on one particle pair per word, fixed point.
// Depends on hds_pkg, hds_sqrt_pipe and hds_div_pipe.
//
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one pair of coordinate
//                 triples and a derivative request per word.
//   out channel : out_valid_o / out_ready_i carry score and the first
//                 particle's derivative increment, one word per input word.
//   cfg port    : cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//                 (rest length, stiffness); write only while idle.
// Throughput: one word per cycle while the output is not stalled.
// Pipeline: stages 1 to 3, the root extraction (35 register stages),
//   stages 4 to 8, the 49-stage quotient pipeline and the output register
//   lie between an accepted word and out_valid_o rising.
// Reset: all stage valid bits clear, rest length 0, stiffness 1.0.
// Stall: while a result waits untaken the whole pipeline holds, and
//   in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module harmonic_distance_score_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire hds_pkg::in_word_t               in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output hds_pkg::out_word_t                   out_word_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [hds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [hds_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import hds_pkg::*;

  logic en;

  logic [REST_W-1:0]  rest_q;
  logic [STIFF_W-1:0] stiff_q;

  // stage 1: deltas
  logic                                v1_q;
  pair_side_t                          side1_q;
  // stage 2: squares
  logic                                v2_q;
  pair_side_t                          side2_q;
  logic [NUM_AXES-1:0][SQ_W-1:0]       sq2_q;
  // stage 3: sum of squares
  logic                                v3_q;
  pair_side_t                          side3_q;
  logic [SUM_W-1:0]                    sum3_q;
  // root
  logic                                vr;
  logic [DIST_W-1:0]                   dist_r;
  pair_side_t                          side_r;
  // stage 4: deviation
  logic                                v4_q;
  pair_side_t                          side4_q;
  logic [DIST_W-1:0]                   d4_q;
  logic                                dneg4_q;
  logic [DIFF_W-1:0]                   dmag4_q;
  // stage 5
  logic                                v5_q;
  logic [T_W-1:0]                      t5_q;
  logic [KD_W-1:0]                     kd5_q;
  logic                                zero5_q;
  logic [DIST_W-1:0]                   den5_q;
  logic [NUM_AXES-1:0]                 sgn5_q;
  logic [NUM_AXES-1:0][MAG_W-1:0]      mag5_q;
  // stage 6
  logic                                v6_q;
  logic [STIFF_W+TL_W-1:0]             pl6_q;
  logic [STIFF_W+TH_W-1:0]             ph6_q;
  logic [DV_W-1:0]                     dv6_q;
  logic                                zero6_q;
  logic [DIST_W-1:0]                   den6_q;
  logic [NUM_AXES-1:0]                 sgn6_q;
  logic [NUM_AXES-1:0][MAG_W-1:0]      mag6_q;
  // stage 7
  logic                                v7_q;
  logic [OUT_W-1:0]                    score7_q;
  logic [NUM_AXES-1:0][DVL_W+MAG_W-1:0] nl7_q;
  logic [NUM_AXES-1:0][DVH_W+MAG_W-1:0] nh7_q;
  logic                                zero7_q;
  logic [DIST_W-1:0]                   den7_q;
  logic [NUM_AXES-1:0]                 sgn7_q;
  // stage 8
  logic                                v8_q;
  logic [NUM_AXES-1:0][NUM_W-1:0]      num8_q;
  logic [DIST_W-1:0]                   den8_q;
  div_side_t                           dside8_q;
  // divider
  logic                                vq;
  logic [NUM_AXES-1:0][OUT_W-1:0]      quo;
  logic [NUM_AXES-1:0]                 qsat;
  div_side_t                           dside_q;
  // output
  logic                                out_valid_q;
  out_word_t                           out_word_q;

  // next values
  pair_side_t                          side1_d;
  logic [DIFF_W-1:0]                   dist_x;
  logic [DIFF_W-1:0]                   rest_x;
  logic                                dneg4_d;
  logic [DIFF_W-1:0]                   dmag4_d;
  logic [KT_W-1:0]                     p7;
  logic [KT_W-1:0]                     s7;
  logic [OUT_W-1:0]                    score7_d;
  logic [NUM_AXES-1:0][OUT_W-1:0]      deriv_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= '0;
      stiff_q <= STIFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_REST_LENGTH: rest_q  <= cfg_wdata_i[REST_W-1:0];
        REG_STIFFNESS:   stiff_q <= cfg_wdata_i[STIFF_W-1:0];
        default:         rest_q  <= rest_q;
      endcase
    end
  end

  always_comb begin
    logic [COORD_W-1:0] a [NUM_AXES];
    logic [COORD_W-1:0] b [NUM_AXES];
    logic [MAG_W-1:0]   dl;
    a[0] = in_word_i.first_x;  b[0] = in_word_i.second_x;
    a[1] = in_word_i.first_y;  b[1] = in_word_i.second_y;
    a[2] = in_word_i.first_z;  b[2] = in_word_i.second_z;
    side1_d.want = in_word_i.want_derivatives;
    for (int i = 0; i < NUM_AXES; i++) begin
      dl = {a[i][COORD_W-1], a[i]} - {b[i][COORD_W-1], b[i]};
      side1_d.neg[i] = dl[MAG_W-1];
      side1_d.mag[i] = dl[MAG_W-1] ? (~dl + MAG_W'(1)) : dl;
    end
  end

  always_comb begin
    dist_x  = DIFF_W'(dist_r);
    rest_x  = DIFF_W'(rest_q);
    dneg4_d = (dist_x < rest_x);
    dmag4_d = dneg4_d ? (rest_x - dist_x) : (dist_x - rest_x);
  end

  always_comb begin
    p7 = KT_W'(pl6_q) + (KT_W'(ph6_q) << TL_W);
    s7 = p7 >> SCORE_SH;
    score7_d = (|s7[KT_W-1:OUT_W]) ? '1 : s7[OUT_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      priority if (dside_q.zero) begin
        deriv_d[i] = '0;
      end else if (dside_q.sgn[i]) begin
        deriv_d[i] = (qsat[i] || quo[i][OUT_W-1]) ? NEG_MAX : (~quo[i] + OUT_W'(1));
      end else begin
        deriv_d[i] = (qsat[i] || quo[i][OUT_W-1]) ? POS_MAX : quo[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= vr;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      out_valid_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;

      side2_q <= side1_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        sq2_q[i] <= side1_q.mag[i] * side1_q.mag[i];
      end

      side3_q <= side2_q;
      sum3_q  <= SUM_W'(sq2_q[0]) + SUM_W'(sq2_q[1]) + SUM_W'(sq2_q[2]);

      side4_q <= side_r;
      d4_q    <= dist_r;
      dneg4_q <= dneg4_d;
      dmag4_q <= dmag4_d;

      t5_q    <= dmag4_q * dmag4_q;
      kd5_q   <= stiff_q * dmag4_q;
      zero5_q <= !side4_q.want || (d4_q == '0);
      den5_q  <= (d4_q == '0) ? DIST_W'(1) : d4_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        sgn5_q[i] <= dneg4_q ^ side4_q.neg[i];
      end
      mag5_q  <= side4_q.mag;

      pl6_q   <= stiff_q * t5_q[TL_W-1:0];
      ph6_q   <= stiff_q * t5_q[T_W-1:TL_W];
      dv6_q   <= kd5_q[KD_W-1:FRAC_BITS];
      zero6_q <= zero5_q;
      den6_q  <= den5_q;
      sgn6_q  <= sgn5_q;
      mag6_q  <= mag5_q;

      score7_q <= score7_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        nl7_q[i] <= dv6_q[DVL_W-1:0] * mag6_q[i];
        nh7_q[i] <= dv6_q[DV_W-1:DVL_W] * mag6_q[i];
      end
      zero7_q <= zero6_q;
      den7_q  <= den6_q;
      sgn7_q  <= sgn6_q;

      for (int i = 0; i < NUM_AXES; i++) begin
        num8_q[i] <= NUM_W'(nl7_q[i]) + (NUM_W'(nh7_q[i]) << DVL_W);
      end
      den8_q         <= den7_q;
      dside8_q.score <= score7_q;
      dside8_q.zero  <= zero7_q;
      dside8_q.sgn   <= sgn7_q;

      out_word_q.score   <= dside_q.score;
      out_word_q.deriv_x <= deriv_d[0];
      out_word_q.deriv_y <= deriv_d[1];
      out_word_q.deriv_z <= deriv_d[2];
    end
  end

  hds_sqrt_pipe #(
    .IN_W   (SUM_W),
    .SIDE_W ($bits(pair_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  (side3_q),
    .valid_o (vr),
    .root_o  (dist_r),
    .side_o  (side_r)
  );

  hds_div_pipe #(
    .NUM_W  (NUM_W),
    .DEN_W  (DIST_W),
    .Q_W    (OUT_W),
    .LANES  (NUM_AXES),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_i   (num8_q),
    .den_i   (den8_q),
    .side_i  (dside8_q),
    .valid_o (vq),
    .q_o     (quo),
    .sat_o   (qsat),
    .side_o  (dside_q)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // pipeline may take a word only when the output slot is empty or frees this cycle
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("word accepted while output stalled");

  // a held pipeline keeps its first stage and its output valid
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(out_valid_q))
    else $error("pipeline moved during stall");

  // with zero stiffness every field of a result is zero
  a_zero_stiffness: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stiff_q == '0) && $stable(stiff_q) |->
      (out_word_o.score == '0) && (out_word_o.deriv_x == '0) &&
      (out_word_o.deriv_y == '0) && (out_word_o.deriv_z == '0))
    else $error("nonzero result with zero stiffness");

endmodule

`default_nettype wire
